// ===== hdl/led_color_effect_engine_unit_assert.svh =====
// assertion macros for the led color effect engine
// used by the port checker; no other dependencies
`ifndef LED_COLOR_EFFECT_ENGINE_UNIT_ASSERT_SVH
`define LED_COLOR_EFFECT_ENGINE_UNIT_ASSERT_SVH
// implication checked on every clock unless reset
`define LCE_ASSERT_IMP(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);
// next-cycle implication
`define LCE_ASSERT_NXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`endif

// ===== hdl/lce_pkg.sv =====
// types and constants for the led color effect engine
// no dependencies
package lce_pkg;
   typedef enum logic [2:0] {
      ACT_TICK   = 3'd0,
      ACT_SINGLE = 3'd1,
      ACT_FADE   = 3'd2,
      ACT_STROBE = 3'd3,
      ACT_OFF    = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      EFF_SINGLE = 2'd0,
      EFF_FADE   = 2'd1,
      EFF_STROBE = 2'd2
   } effect_type;

   localparam logic [1:0] EASE_LINEAR = 2'd0;
   localparam logic [1:0] EASE_IN     = 2'd1;
   localparam logic [1:0] EASE_OUT    = 2'd2;
   localparam logic [1:0] EASE_INOUT  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_SQ,
      ST_CUBE,
      ST_EASE,
      ST_CH0,
      ST_CH1,
      ST_CH2,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  end_red;
      logic [7:0]  end_green;
      logic [7:0]  end_blue;
      logic [15:0] duration;
      logic [1:0]  easing;
      logic [15:0] strobe_period;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       color_written;
   } rsp_type;
endpackage

// ===== hdl/lce_divider.sv =====
// restoring divider: one quotient bit per cycle
// depends on nothing but its ports
module lce_divider #(
   parameter int NUM_BITS = 33,
   parameter int DEN_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numer,
   input  logic [DEN_BITS-1:0] denom,
   output logic                done,
   output logic [NUM_BITS-1:0] quot
);
   localparam int CW = $clog2(NUM_BITS + 1);
   logic [NUM_BITS-1:0] q_ff, q_in;
   logic [DEN_BITS:0]   r_ff, r_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [DEN_BITS:0]   trial;

   // load on start, else one shift-subtract step
   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = '0;
      if (start) begin
         q_in = numer;
         r_in = '0;
         cnt_in = CW'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {r_ff[DEN_BITS-1:0], q_ff[NUM_BITS-1]};
         if (trial >= {1'b0, denom}) begin
            r_in = trial - {1'b0, denom};
            q_in = {q_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign done = busy_ff && cnt_ff == CW'(1);
   assign quot = q_in;
endmodule

// ===== hdl/led_color_effect_engine_unit.sv =====
// led color effect engine top level: sequencer, state and one shared multiplier
// depends on lce_pkg and lce_divider
//
// Each item gives exactly one result. Commands, and ticks that do not
// advance a running fade, go from accept to the output step and then to the
// result. A tick during a fade runs the progress divide on the bit-serial
// divider, then up to five steps through the single shared multiplier
// (square, cube, three channels; linear easing skips square and cube) plus
// one ease step and one output step.
// The input is not ready while an item is at work; a finished result waits
// in the output register.
module led_color_effect_engine_unit #(
   parameter int TIME_BITS = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lce_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lce_pkg::rsp_type rsp_data
);
   import lce_pkg::*;

   localparam int F  = FRACTION_BITS;
   localparam int EW = TIME_BITS + 1;
   localparam int NW = EW + F;
   localparam int MW = F + 2;
   localparam logic [EW-1:0] EMAX = {EW{1'b1}};
   localparam logic [MW-1:0] ONE = MW'(1) << F;
   localparam int TB = (TIME_BITS < 16) ? TIME_BITS : 16;

   state_type st_ff, st_in;
   effect_type eff_ff, eff_in;
   logic [1:0] curve_ff, curve_in;
   logic [7:0] sc_ff [3], sc_in [3];
   logic [7:0] tc_ff [3], tc_in [3];
   logic [7:0] fc_ff [3], fc_in [3];
   logic [7:0] shc_ff [3], shc_in [3];
   logic [TIME_BITS-1:0] flen_ff, flen_in, fper_ff, fper_in;
   logic [EW-1:0] el_ff, el_in, el_inc;
   logic flon_ff, flon_in;
   logic [MW-1:0] p_ff, p_in, x_ff, x_in, e_ff, e_in;
   logic wr_ff, wr_in;
   logic rv_ff, rv_in;
   rsp_type rsp_ff, rsp_in;

   // shared multiplier operands
   logic [MW-1:0] ma, mb;
   logic [2*MW-1:0] mprod;
   logic [MW-1:0] mres;

   logic div_start, div_done;
   logic [NW-1:0] div_q;
   logic [7:0] s_c, t_c, dmag;

   lce_divider #(.NUM_BITS(NW), .DEN_BITS(TIME_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer({el_inc, {F{1'b0}}}), .denom(flen_ff),
      .done(div_done), .quot(div_q)
   );

   assign el_inc = (el_ff < EMAX) ? el_ff + 1'b1 : el_ff;
   assign req_ready = (st_ff == ST_IDLE) && !rv_ff;

   // channel operands for the blend steps
   always_comb begin
      s_c = sc_ff[0];
      t_c = tc_ff[0];
      case (st_ff)
         ST_CH1: begin s_c = sc_ff[1]; t_c = tc_ff[1]; end
         ST_CH2: begin s_c = sc_ff[2]; t_c = tc_ff[2]; end
         default: ;
      endcase
      dmag = (t_c >= s_c) ? t_c - s_c : s_c - t_c;
   end

   // multiplier input select
   always_comb begin
      ma = x_ff;
      mb = x_ff;
      case (st_ff)
         ST_SQ:   begin ma = x_ff; mb = x_ff; end
         ST_CUBE: begin ma = e_ff; mb = x_ff; end
         ST_CH0, ST_CH1, ST_CH2: begin ma = e_ff; mb = MW'(dmag); end
         default: ;
      endcase
      mprod = ma * mb;
      mres = mprod[F +: MW];
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (req_valid && req_ready) begin
            if (req_data.action == ACT_TICK && eff_ff == EFF_FADE && el_inc <= EW'(flen_ff))
               st_in = ST_DIV;
            else
               st_in = ST_OUT;
         end
         ST_DIV:  if (div_done) st_in = (curve_ff == EASE_LINEAR) ? ST_EASE : ST_SQ;
         ST_SQ:   st_in = ST_CUBE;
         ST_CUBE: st_in = ST_EASE;
         ST_EASE: st_in = ST_CH0;
         ST_CH0:  st_in = ST_CH1;
         ST_CH1:  st_in = ST_CH2;
         ST_CH2:  st_in = ST_OUT;
         ST_OUT:  st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // datapath and state updates
   always_comb begin
      logic [MW+1:0] c4;
      logic [MW-1:0] cv, ev;
      c4 = '0;
      cv = '0;
      ev = '0;
      eff_in = eff_ff; curve_in = curve_ff;
      sc_in = sc_ff; tc_in = tc_ff; fc_in = fc_ff; shc_in = shc_ff;
      flen_in = flen_ff; fper_in = fper_ff; el_in = el_ff; flon_in = flon_ff;
      p_in = p_ff; x_in = x_ff; e_in = e_ff; wr_in = wr_ff;
      rv_in = rv_ff; rsp_in = rsp_ff;
      div_start = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (st_ff)
         ST_IDLE: if (req_valid && req_ready) begin
            wr_in = 1'b0;
            case (req_data.action)
               ACT_TICK: begin
                  el_in = el_inc;
                  if (eff_ff == EFF_FADE) begin
                     if (el_inc > EW'(flen_ff)) eff_in = EFF_SINGLE;
                     else div_start = 1'b1;
                  end else if (eff_ff == EFF_STROBE && el_inc >= EW'(fper_ff)) begin
                     for (int i = 0; i < 3; i++) shc_in[i] = flon_ff ? fc_ff[i] : 8'd0;
                     flon_in = !flon_ff;
                     el_in = '0;
                     wr_in = 1'b1;
                  end
               end
               ACT_SINGLE: begin
                  eff_in = EFF_SINGLE;
                  shc_in[0] = req_data.red; shc_in[1] = req_data.green;
                  shc_in[2] = req_data.blue;
                  wr_in = 1'b1;
               end
               ACT_FADE: begin
                  sc_in[0] = req_data.red; sc_in[1] = req_data.green;
                  sc_in[2] = req_data.blue;
                  tc_in[0] = req_data.end_red; tc_in[1] = req_data.end_green;
                  tc_in[2] = req_data.end_blue;
                  shc_in[0] = req_data.red; shc_in[1] = req_data.green;
                  shc_in[2] = req_data.blue;
                  flen_in = TIME_BITS'(req_data.duration[TB-1:0]);
                  curve_in = req_data.easing;
                  el_in = '0;
                  eff_in = EFF_FADE;
                  wr_in = 1'b1;
               end
               ACT_STROBE: begin
                  fc_in[0] = req_data.red; fc_in[1] = req_data.green;
                  fc_in[2] = req_data.blue;
                  shc_in[0] = req_data.red; shc_in[1] = req_data.green;
                  shc_in[2] = req_data.blue;
                  fper_in = TIME_BITS'(req_data.strobe_period[TB-1:0]);
                  el_in = '0;
                  flon_in = 1'b0;
                  eff_in = EFF_STROBE;
                  wr_in = 1'b1;
               end
               ACT_OFF: begin
                  eff_in = EFF_SINGLE;
                  for (int i = 0; i < 3; i++) shc_in[i] = 8'd0;
                  wr_in = 1'b1;
               end
               default: ;
            endcase
         end
         ST_DIV: if (div_done) begin
            // progress never exceeds one here
            p_in = div_q[MW-1:0];
            if (curve_ff == EASE_IN || (curve_ff == EASE_INOUT && div_q[MW-1:0] < (ONE >> 1)))
               x_in = div_q[MW-1:0];
            else
               x_in = ONE - div_q[MW-1:0];
            e_in = div_q[MW-1:0];
         end
         ST_SQ:   e_in = mres;
         ST_CUBE: e_in = mres;
         ST_EASE: begin
            cv = e_ff;
            c4 = {cv, 2'b00};
            case (curve_ff)
               EASE_IN: ev = cv;
               EASE_OUT: ev = (cv > ONE) ? '0 : ONE - cv;
               EASE_INOUT: begin
                  if (p_ff < (ONE >> 1)) ev = (c4 > (MW+2)'(ONE)) ? ONE : c4[MW-1:0];
                  else ev = (c4 > (MW+2)'(ONE)) ? '0 : ONE - c4[MW-1:0];
               end
               default: ev = p_ff;
            endcase
            e_in = (ev > ONE) ? ONE : ev;
         end
         ST_CH0, ST_CH1, ST_CH2: begin
            for (int i = 0; i < 3; i++) begin
               if ((st_ff == ST_CH0 && i == 0) || (st_ff == ST_CH1 && i == 1) ||
                   (st_ff == ST_CH2 && i == 2))
                  shc_in[i] = (t_c >= s_c) ? s_c + mres[7:0] : s_c - mres[7:0];
            end
            wr_in = 1'b1;
         end
         ST_OUT: begin
            rsp_in.out_red = shc_ff[0];
            rsp_in.out_green = shc_ff[1];
            rsp_in.out_blue = shc_ff[2];
            rsp_in.color_written = wr_ff;
            rv_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         eff_ff <= EFF_SINGLE;
         curve_ff <= EASE_LINEAR;
         for (int i = 0; i < 3; i++) begin
            sc_ff[i] <= '0; tc_ff[i] <= '0; fc_ff[i] <= '0; shc_ff[i] <= '0;
         end
         flen_ff <= '0;
         fper_ff <= '0;
         el_ff <= '0;
         flon_ff <= 1'b0;
         rv_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         eff_ff <= eff_in;
         curve_ff <= curve_in;
         sc_ff <= sc_in; tc_ff <= tc_in; fc_ff <= fc_in; shc_ff <= shc_in;
         flen_ff <= flen_in;
         fper_ff <= fper_in;
         el_ff <= el_in;
         flon_ff <= flon_in;
         rv_ff <= rv_in;
         wr_ff <= wr_in;
      end
      p_ff <= p_in;
      x_ff <= x_in;
      e_ff <= e_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;
endmodule

// ===== hdl/lce_checker.sv =====
// port-level checker for the led color effect engine, bound to the top level
// depends on lce_pkg and the assertion macro header
`include "led_color_effect_engine_unit_assert.svh"
module lce_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input lce_pkg::rsp_type rsp_data
);
   import lce_pkg::*;
   // no new item while a result is pending
   `LCE_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready, "accepted while result pending")
   // an accepted item never produces a result the next cycle
   `LCE_ASSERT_NXT(a_no_instant, clock, reset, req_valid && req_ready, !rsp_valid, "result too early")
   // a stalled result stays valid and unchanged
   `LCE_ASSERT_NXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")
endmodule

bind led_color_effect_engine_unit lce_checker u_lce_checker (.*);

// ===== tb/tb_led_color_effect_engine_unit.sv =====
// testbench for the led color effect engine: random and directed commands and ticks
// depends on lce_pkg and the engine rtl; predicts each result and checks it in order
`timescale 1ns / 1ps

module tb_led_color_effect_engine_unit;
   import lce_pkg::*;

   localparam int FRAC = 16;
   localparam logic [16:0] ONE = 17'h10000;
   localparam logic [16:0] ELAPSED_TOP = 17'h1ffff;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   led_color_effect_engine_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // predicted engine state
   effect_type  eff_q = EFF_SINGLE;
   logic [1:0]  curve_q = EASE_LINEAR;
   logic [7:0]  start_q [3] = '{default: 8'd0};
   logic [7:0]  target_q [3] = '{default: 8'd0};
   logic [7:0]  flash_q [3] = '{default: 8'd0};
   logic [7:0]  shown_q [3] = '{default: 8'd0};
   logic [15:0] fade_len_q = '0;
   logic [15:0] flash_per_q = '0;
   logic [16:0] elapsed_q = '0;
   logic        flash_on_q = 1'b0;

   req_type pending_items [$];
   rsp_type expected_colors [$];
   int      mismatches = 0;
   int      checked = 0;
   int      n_fades = 0;
   int      n_strobes = 0;
   bit      idle_free = 0;
   bit      hold_off = 0;
   bit      stim_done = 0;

   function automatic logic [63:0] cube(logic [63:0] x);
      logic [63:0] sq;
      sq = (x * x) >> FRAC;
      return (sq * x) >> FRAC;
   endfunction

   function automatic logic [63:0] eased(logic [63:0] p, logic [1:0] c);
      logic [63:0] g, e, k;
      g = ONE - p;
      case (c)
         EASE_IN: e = cube(p);
         EASE_OUT: begin
            k = cube(g);
            e = (k > ONE) ? 0 : ONE - k;
         end
         EASE_INOUT: begin
            if (p < (ONE >> 1)) begin
               e = cube(p) << 2;
            end else begin
               k = cube(g) << 2;
               e = (k > ONE) ? 0 : ONE - k;
            end
         end
         default: e = p;
      endcase
      return (e > ONE) ? ONE : e;
   endfunction

   function automatic bit tick_engine();
      logic [63:0] p, e, mag;
      if (elapsed_q < ELAPSED_TOP) elapsed_q++;
      if (eff_q == EFF_FADE) begin
         if (elapsed_q > fade_len_q) begin
            eff_q = EFF_SINGLE;
            return 0;
         end
         p = ({47'd0, elapsed_q} << FRAC) / fade_len_q;
         e = eased(p, curve_q);
         for (int i = 0; i < 3; i++) begin
            if (target_q[i] >= start_q[i]) begin
               mag = (e * (target_q[i] - start_q[i])) >> FRAC;
               shown_q[i] = start_q[i] + mag[7:0];
            end else begin
               mag = (e * (start_q[i] - target_q[i])) >> FRAC;
               shown_q[i] = start_q[i] - mag[7:0];
            end
         end
         return 1;
      end
      if (eff_q == EFF_STROBE && elapsed_q >= flash_per_q) begin
         for (int i = 0; i < 3; i++) shown_q[i] = flash_on_q ? flash_q[i] : 8'd0;
         flash_on_q ^= 1'b1;
         elapsed_q = '0;
         return 1;
      end
      return 0;
   endfunction

   function automatic rsp_type predict_color(req_type it);
      rsp_type r;
      bit wr;
      wr = 0;
      case (it.action)
         ACT_TICK: wr = tick_engine();
         ACT_SINGLE: begin
            eff_q = EFF_SINGLE;
            shown_q = '{it.red, it.green, it.blue};
            wr = 1;
         end
         ACT_FADE: begin
            start_q = '{it.red, it.green, it.blue};
            target_q = '{it.end_red, it.end_green, it.end_blue};
            fade_len_q = it.duration;
            curve_q = it.easing;
            elapsed_q = '0;
            eff_q = EFF_FADE;
            shown_q = '{it.red, it.green, it.blue};
            wr = 1;
            n_fades++;
         end
         ACT_STROBE: begin
            flash_q = '{it.red, it.green, it.blue};
            flash_per_q = it.strobe_period;
            elapsed_q = '0;
            flash_on_q = 1'b0;
            eff_q = EFF_STROBE;
            shown_q = '{it.red, it.green, it.blue};
            wr = 1;
            n_strobes++;
         end
         ACT_OFF: begin
            eff_q = EFF_SINGLE;
            shown_q = '{8'd0, 8'd0, 8'd0};
            wr = 1;
         end
         default: wr = 0;
      endcase
      r.out_red = shown_q[0];
      r.out_green = shown_q[1];
      r.out_blue = shown_q[2];
      r.color_written = wr;
      return r;
   endfunction

   function automatic req_type rand_item(logic [2:0] act);
      req_type it;
      it = req_type'({$urandom, $urandom, $urandom});
      it.action = act;
      return it;
   endfunction

   function automatic req_type fade_item(int max_len);
      req_type it;
      it = rand_item(ACT_FADE);
      it.duration = 16'($urandom_range(max_len));
      return it;
   endfunction

   function automatic req_type strobe_item(int max_per);
      req_type it;
      it = rand_item(ACT_STROBE);
      it.strobe_period = 16'($urandom_range(max_per));
      return it;
   endfunction

   // driver: offers the next pending item, idles at random
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_colors.push_back(predict_color(req_data));
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && (idle_free || $urandom_range(99) >= 38)) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: takes results with random stalls, checks against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_colors.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected item %p", rsp_data);
            end else begin
               want = expected_colors.pop_front();
               if (rsp_data.out_red !== want.out_red || rsp_data.out_green !== want.out_green ||
                   rsp_data.out_blue !== want.out_blue ||
                   rsp_data.color_written !== want.color_written) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at %0t: expected %p, got %p", $realtime, want, rsp_data);
               end
            end
         end
         rsp_ready <= !hold_off && (idle_free || $urandom_range(99) >= 38);
      end
   end

   // receiver hold-off, counted in its own process
   initial begin
      wait (stim_done == 0 && checked > 300);
      hold_off = 1;
      repeat (400) @(posedge clock);
      hold_off = 0;
   end

   // stimulus
   initial begin
      req_type it;
      int kind;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every action, zero duration and zero period
      it = '0; it.action = ACT_TICK; pending_items.push_back(it);
      it = '1; it.action = ACT_SINGLE; pending_items.push_back(it);
      it = '0; it.action = ACT_TICK; pending_items.push_back(it);
      it = '1; it.action = ACT_FADE; it.duration = 0; pending_items.push_back(it);
      it = '0; it.action = ACT_TICK; pending_items.push_back(it);
      pending_items.push_back(it);
      for (int c = 0; c < 4; c++) begin
         it = '0; it.action = ACT_FADE; it.red = 8'hff; it.end_green = 8'hff;
         it.duration = 3; it.easing = c[1:0]; pending_items.push_back(it);
         it = '0; it.action = ACT_TICK;
         repeat (4) pending_items.push_back(it);
      end
      it = '1; it.action = ACT_STROBE; it.strobe_period = 0; pending_items.push_back(it);
      it = '0; it.action = ACT_TICK; repeat (2) pending_items.push_back(it);
      it = '0; it.action = ACT_OFF; pending_items.push_back(it);
      it = '1; it.action = 3'd7; pending_items.push_back(it);
      it = '1; it.action = ACT_FADE; it.duration = 16'hffff; pending_items.push_back(it);
      it = '0; it.action = ACT_TICK; pending_items.push_back(it);

      // random: mostly well-formed effects followed by runs of ticks
      while (pending_items.size() + checked < 1550) begin
         kind = $urandom_range(9);
         if (kind < 4) begin
            pending_items.push_back(($urandom_range(9) == 0) ? fade_item(65535) : fade_item(40));
            repeat ($urandom_range(45)) pending_items.push_back(rand_item(ACT_TICK));
         end else if (kind < 7) begin
            pending_items.push_back(($urandom_range(9) == 0) ? strobe_item(65535) : strobe_item(5));
            repeat ($urandom_range(20)) pending_items.push_back(rand_item(ACT_TICK));
         end else if (kind == 7) begin
            pending_items.push_back(rand_item($urandom_range(1) ? ACT_SINGLE : ACT_OFF));
            pending_items.push_back(rand_item(ACT_TICK));
         end else if (kind == 8) begin
            pending_items.push_back(rand_item(3'($urandom_range(7))));
         end else begin
            // burst with no random idling on either side
            idle_free = 1;
            pending_items.push_back(fade_item(30));
            repeat (30) pending_items.push_back(rand_item(ACT_TICK));
            wait (pending_items.size() == 0);
            idle_free = 0;
         end
         if (pending_items.size() > 60) wait (pending_items.size() < 20);
      end

      wait (pending_items.size() == 0 && !req_valid);
      wait (expected_colors.size() == 0);
      repeat (100) @(posedge clock);
      stim_done = 1;
      $display("covered %0d items: %0d fades, %0d strobes, all actions and easings",
               checked, n_fades, n_strobes);
      if (mismatches == 0 && expected_colors.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/lce_pkg.sv
hdl/lce_divider.sv
hdl/led_color_effect_engine_unit.sv
hdl/lce_checker.sv
tb/tb_led_color_effect_engine_unit.sv
